[design/ghst_pkg.sv]
// ----------------------------------------------------------------------------
// ghst_pkg
// Shared constants and types for the generational handle slot table.
// ----------------------------------------------------------------------------
package ghst_pkg;

	localparam int SLOT_COUNT      = 256;
	localparam int SLOT_IDX_W      = $clog2(SLOT_COUNT);
	localparam int SLOT_FIELD_BITS = 24;
	localparam int GEN_W           = 8;
	localparam int HANDLE_W        = SLOT_FIELD_BITS + GEN_W;
	localparam int ENTITY_W        = 64;
	localparam int CMD_W           = 2;
	localparam int STAT_W          = 2;
	localparam int LIVE_W          = 9;

	localparam int GRP_SIZE        = 16;
	localparam int GRP_COUNT       = SLOT_COUNT / GRP_SIZE;
	localparam int GRP_BIT_W       = $clog2(GRP_SIZE);
	localparam int GRP_IDX_W       = $clog2(GRP_COUNT);

	localparam logic [GEN_W-1:0] GEN_MAX = {GEN_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic                  found;
		logic [SLOT_IDX_W-1:0] slot;
	} find_t;

endpackage

[design/ghst_ram.sv]
// ----------------------------------------------------------------------------
// ghst_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ghst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/ghst_finder.sv]
// ----------------------------------------------------------------------------
// ghst_finder
// Two-step lowest free slot search: registered per-group flags, then a
// group pick and a bit pick within that group.
// ----------------------------------------------------------------------------
module ghst_finder import ghst_pkg::*; (
	input  logic                  clk,
	input  logic [SLOT_COUNT-1:0] avail,
	output find_t                 find
);

	logic [GRP_COUNT-1:0] grp_any_q;
	logic [GRP_IDX_W-1:0] grp_sel;
	logic [GRP_BIT_W-1:0] bit_sel;
	logic [GRP_SIZE-1:0]  grp_bits;

	always_ff @(posedge clk) begin
		for (int g = 0; g < GRP_COUNT; g++) begin
			grp_any_q[g] <= |avail[g*GRP_SIZE +: GRP_SIZE];
		end
	end

	always_comb begin
		grp_sel = '0;
		for (int g = GRP_COUNT - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				grp_sel = GRP_IDX_W'(g);
			end
		end
		grp_bits = avail[grp_sel*GRP_SIZE +: GRP_SIZE];
		bit_sel = '0;
		for (int b = GRP_SIZE - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				bit_sel = GRP_BIT_W'(b);
			end
		end
		find.found = |grp_any_q;
		find.slot  = {grp_sel, bit_sel};
	end

endmodule

[design/generational_handle_slot_table.sv]
// ----------------------------------------------------------------------------
// generational_handle_slot_table
// Slot table handing out generational handles (allocate, resolve, free).
//
// Input channel: in_valid/in_ready with command, handle, entity_value.
// Output channel: out_valid/out_ready with handle_out, entity_out, status,
// live_count. Every item gives exactly one result item.
// The result is registered as the item leaves execute. A new item is
// taken only once the last has left execute; the sequencer runs accept,
// group search, slot pick plus memory read, then execute plus write-back.
// Generation and entity values live in synchronous RAMs with a registered
// read port; live and quarantine flags are flops feeding the search.
// Reset clears all flags, generation valid bits and the live count at
// once; no clearing pass is needed and an item may be taken right away.
// When the receiver stalls, the result waits in the output register; the
// block still takes the next item and holds in execute until the output
// register frees up.
// ----------------------------------------------------------------------------
module generational_handle_slot_table import ghst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [ENTITY_W-1:0] entity_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [ENTITY_W-1:0] entity_out,
	output logic [STAT_W-1:0]   status,
	output logic [LIVE_W-1:0]   live_count
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SRCH = 4'b0010,
		S_PICK = 4'b0100,
		S_EXEC = 4'b1000
	} state_t;

	state_t state_q;

	logic [CMD_W-1:0]      cmd_q;
	logic [HANDLE_W-1:0]   hnd_q;
	logic [ENTITY_W-1:0]   ent_q;
	logic [SLOT_IDX_W-1:0] addr_q;
	logic                  found_q;
	logic                  rd_gvld_q;

	logic [SLOT_COUNT-1:0] live_q;
	logic [SLOT_COUNT-1:0] quar_q;
	logic [SLOT_COUNT-1:0] gen_vld_q;
	logic [LIVE_W-1:0]     live_total_q;

	logic                  out_valid_q;
	logic [HANDLE_W-1:0]   handle_out_q;
	logic [ENTITY_W-1:0]   entity_out_q;
	logic [STAT_W-1:0]     status_q;
	logic [LIVE_W-1:0]     live_count_q;

	find_t                     find;
	logic [SLOT_FIELD_BITS-1:0] raw;
	logic                      hnd_in_range;
	logic [SLOT_IDX_W-1:0]     hidx;
	logic [SLOT_IDX_W-1:0]     rd_addr;
	logic [GEN_W-1:0]          gen_rd;
	logic [GEN_W-1:0]          gen_eff;
	logic [ENTITY_W-1:0]       ent_rd;
	logic                      exec_go;

	logic                      ent_we;
	logic                      gen_we;
	logic                      set_live;
	logic                      clr_live;
	logic                      set_quar;
	logic [HANDLE_W-1:0]       hout_n;
	logic [ENTITY_W-1:0]       eout_n;
	logic [STAT_W-1:0]         stat_n;
	logic [LIVE_W-1:0]         total_n;

	assign in_ready = (state_q == S_IDLE);
	assign exec_go  = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	assign raw          = hnd_q[SLOT_FIELD_BITS-1:0];
	assign hnd_in_range = (raw <= SLOT_FIELD_BITS'(SLOT_COUNT));
	assign hidx         = (raw == '0) ? '0 : SLOT_IDX_W'(raw - SLOT_FIELD_BITS'(1));
	assign rd_addr      = (cmd_q == CMD_ALLOC) ? find.slot : hidx;
	assign gen_eff      = rd_gvld_q ? gen_rd : '0;

	ghst_finder u_finder (
		.clk   (clk),
		.avail (~live_q & ~quar_q),
		.find  (find)
	);

	ghst_ram #(
		.WIDTH (GEN_W),
		.DEPTH (SLOT_COUNT)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (addr_q),
		.wdata (gen_eff + GEN_W'(1)),
		.re    (state_q == S_PICK),
		.raddr (rd_addr),
		.rdata (gen_rd)
	);

	ghst_ram #(
		.WIDTH (ENTITY_W),
		.DEPTH (SLOT_COUNT)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (addr_q),
		.wdata (ent_q),
		.re    (state_q == S_PICK),
		.raddr (rd_addr),
		.rdata (ent_rd)
	);

	always_comb begin
		ent_we   = 1'b0;
		gen_we   = 1'b0;
		set_live = 1'b0;
		clr_live = 1'b0;
		set_quar = 1'b0;
		hout_n   = '0;
		eout_n   = '0;
		stat_n   = STAT_BAD;
		total_n  = live_total_q;
		case (cmd_q)
			CMD_ALLOC: begin
				if (found_q) begin
					ent_we   = exec_go;
					set_live = exec_go;
					hout_n   = {gen_eff, SLOT_FIELD_BITS'(addr_q) + SLOT_FIELD_BITS'(1)};
					stat_n   = STAT_OK;
					total_n  = live_total_q + LIVE_W'(1);
				end else begin
					stat_n = STAT_FULL;
				end
			end
			CMD_RESOLVE: begin
				if ((hnd_q != '0) && hnd_in_range && live_q[addr_q] && !quar_q[addr_q]
						&& (gen_eff == hnd_q[HANDLE_W-1:SLOT_FIELD_BITS])) begin
					eout_n = ent_rd;
					stat_n = STAT_OK;
				end
			end
			CMD_FREE: begin
				if ((hnd_q != '0) && hnd_in_range && live_q[addr_q]) begin
					clr_live = exec_go;
					if (gen_eff == GEN_MAX) begin
						set_quar = exec_go;
					end else begin
						gen_we = exec_go;
					end
					if (live_total_q != '0) begin
						total_n = live_total_q - LIVE_W'(1);
					end
					stat_n = STAT_OK;
				end
			end
			default: begin
				stat_n = STAT_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			live_q       <= '0;
			quar_q       <= '0;
			gen_vld_q    <= '0;
			live_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: state_q <= S_PICK;
				S_PICK: state_q <= S_EXEC;
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (set_live) begin
				live_q[addr_q] <= 1'b1;
			end
			if (clr_live) begin
				live_q[addr_q] <= 1'b0;
			end
			if (set_quar) begin
				quar_q[addr_q] <= 1'b1;
			end
			if (gen_we) begin
				gen_vld_q[addr_q] <= 1'b1;
			end
			if (exec_go) begin
				live_total_q <= total_n;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			hnd_q <= handle;
			ent_q <= entity_value;
		end
		if (state_q == S_PICK) begin
			addr_q    <= rd_addr;
			found_q   <= find.found;
			rd_gvld_q <= gen_vld_q[rd_addr];
		end
		if (exec_go) begin
			handle_out_q <= hout_n;
			entity_out_q <= eout_n;
			status_q     <= stat_n;
			live_count_q <= total_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign handle_out = handle_out_q;
	assign entity_out = entity_out_q;
	assign status     = status_q;
	assign live_count = live_count_q;

endmodule
